[rtl/core/ciw_pkg.sv]
// Shared types and constants of the compacting issue window.
// Used by ciw_cell and compacting_issue_window; depends on nothing.
package ciw_pkg;

    localparam int WINDOW_DEPTH_DEF = 6;

    localparam int OP_W    = 3;
    localparam int REG_W   = 5;
    localparam int OCC_W   = 3;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic OPC_INSERT = 1'b0;
    localparam logic OPC_ISSUE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LAT_TABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_CODE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [REG_W-1:0] src1;
        logic [REG_W-1:0] src2;
        logic [REG_W-1:0] dest;
    } ciw_entry_t;

    localparam int ENTRY_W = $bits(ciw_entry_t);

    // Issue conditions and configuration, broadcast to every cell.
    typedef struct packed {
        logic [31:0]     reg_ready;
        logic [15:0]     port_busy;
        logic            float_free;
        logic [31:0]     lat_table;
        logic [OP_W-1:0] store_code;
        logic [OP_W-1:0] float_code;
    } ciw_req_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic occupied;
        logic issue;
        logic load;
    } ciw_cell_ctl_t;

endpackage

[rtl/core/ciw_cell.sv]
// One slot of the compacting issue window: entry storage, readiness check
// and one link of the oldest-first select chain. Depends on ciw_pkg.
module ciw_cell (
    input  logic                  aclk,
    input  ciw_pkg::ciw_req_t     req,
    input  ciw_pkg::ciw_cell_ctl_t ctl,
    input  ciw_pkg::ciw_entry_t   ins_entry,
    input  ciw_pkg::ciw_entry_t   nbr_entry,
    input  logic                  found_in,
    output logic                  found_out,
    output logic                  sel,
    output ciw_pkg::ciw_entry_t   entry
);
    import ciw_pkg::*;

    ciw_entry_t       entry_reg;
    ciw_entry_t       entry_next;
    logic             is_store;
    logic             is_float;
    logic             srcs_ok;
    logic             port_ok;
    logic             can_go;
    logic [3:0]       lat;
    logic [4:0]       slot;

    function automatic logic reg_ok(input logic [REG_W-1:0] r, input logic [31:0] mask);
        reg_ok = (r == '0) || mask[r];
    endfunction

    always_comb begin
        is_store = (entry_reg.op == req.store_code);
        is_float = (entry_reg.op == req.float_code);
        srcs_ok  = reg_ok(entry_reg.src1, req.reg_ready)
                && reg_ok(entry_reg.src2, req.reg_ready)
                && (!is_store || reg_ok(entry_reg.dest, req.reg_ready));
        lat      = req.lat_table[{entry_reg.op, 2'b00} +: 4];
        slot     = {1'b0, lat} + 5'd1;
        // A result slot past the end of the busy mask counts as free.
        port_ok  = is_store || (entry_reg.dest == '0) || slot[4]
                || !req.port_busy[slot[3:0]];
        can_go   = ctl.occupied && srcs_ok && port_ok && (!is_float || req.float_free);
        sel       = can_go && !found_in;
        found_out = found_in || can_go;
    end

    always_comb begin
        priority if (ctl.load) begin
            entry_next = ins_entry;
        end else if (ctl.issue && found_out) begin
            entry_next = nbr_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[rtl/core/compacting_issue_window.sv]
// Top level of the compacting issue window: fill count, configuration
// registers, the row of ciw_cell slots and the result register.
// Depends on ciw_pkg and ciw_cell.
//
// Usage: each input beat on the s_ channel is either an insert
// (s_opcode = insert) that appends an instruction at the tail of the window,
// or an issue request that removes the oldest instruction whose registers,
// write-back slot and float unit are all available. Younger entries then
// move forward by one slot, so slot 0 always holds the oldest instruction.
// Every input beat produces exactly one result beat on the m_ channel with
// the issued instruction (all zero when nothing issued), the occupancy after
// the beat, a space flag and an overflow flag for a dropped insert.
// The result is registered and appears in the cycle after the input beat is
// accepted. One beat per cycle is sustained: the readiness check, the select
// chain along the cells and the compaction all settle within the accepting
// cycle, and the result register decouples the two channels. s_ready drops
// only while a result waits in that register and m_ready is low.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must do so only while the block is idle, which it does not enforce.
// Reset clears the fill count, the configuration registers and the m_valid
// flag; slot contents, result data bits and m_issued_valid are not cleared.
module compacting_issue_window #(
    parameter int WINDOW_DEPTH = ciw_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ciw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ciw_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [2:0]                    s_instr_op,
    input  logic [4:0]                    s_instr_src1,
    input  logic [4:0]                    s_instr_src2,
    input  logic [4:0]                    s_instr_dest,
    input  logic [31:0]                   s_reg_ready_mask,
    input  logic [15:0]                   s_write_port_busy,
    input  logic                          s_float_unit_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_issued_valid,
    output logic [2:0]                    m_issued_op,
    output logic [4:0]                    m_issued_src1,
    output logic [4:0]                    m_issued_src2,
    output logic [4:0]                    m_issued_dest,
    output logic [2:0]                    m_occupancy,
    output logic                          m_has_space,
    output logic                          m_insert_overflow
);
    import ciw_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    // Configuration registers.
    logic [31:0]     lat_table_reg;
    logic [OP_W-1:0] store_code_reg;
    logic [OP_W-1:0] float_code_reg;

    // Fill count: slots below it hold instructions in program order.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result register.
    logic             m_valid_reg;
    logic             res_valid_reg;
    ciw_entry_t       res_entry_reg;
    logic [OCC_W-1:0] res_occ_reg;
    logic             res_space_reg;
    logic             res_ovf_reg;

    logic             accept;
    logic             do_insert;
    logic             do_issue;
    logic             full;
    logic             any_go;
    ciw_req_t         req;
    ciw_entry_t       ins_entry;
    ciw_entry_t       picked;

    logic [WINDOW_DEPTH:0]   found;
    logic [WINDOW_DEPTH-1:0] sel;
    ciw_entry_t              entries [WINDOW_DEPTH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign do_insert = accept && (s_opcode == OPC_INSERT);
    assign do_issue  = accept && (s_opcode == OPC_ISSUE);
    assign full      = (count_reg == CNT_W'(WINDOW_DEPTH));

    assign req = '{
        reg_ready:  s_reg_ready_mask,
        port_busy:  s_write_port_busy,
        float_free: s_float_unit_free,
        lat_table:  lat_table_reg,
        store_code: store_code_reg,
        float_code: float_code_reg
    };

    assign ins_entry = '{
        op:   s_instr_op,
        src1: s_instr_src1,
        src2: s_instr_src2,
        dest: s_instr_dest
    };

    // The select chain starts at the oldest slot; found[i] says that some
    // slot older than i can issue, so slot i and all younger ones shift.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        ciw_cell_ctl_t ctl;
        ciw_entry_t    nbr;

        assign ctl.occupied = (count_reg > CNT_W'(i));
        assign ctl.issue    = do_issue;
        assign ctl.load     = do_insert && !full && (count_reg == CNT_W'(i));

        if (i == WINDOW_DEPTH - 1) begin : g_last
            // The youngest slot has no neighbor; its content is stale after a
            // shift and lies beyond the fill count.
            assign nbr = entries[i];
        end else begin : g_mid
            assign nbr = entries[i+1];
        end

        ciw_cell u_cell (
            .aclk      (aclk),
            .req       (req),
            .ctl       (ctl),
            .ins_entry (ins_entry),
            .nbr_entry (nbr),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .sel       (sel[i]),
            .entry     (entries[i])
        );
    end

    assign any_go = found[WINDOW_DEPTH];

    // The select vector is one-hot, so an AND-OR mux picks the entry.
    always_comb begin
        picked = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            picked = picked | (entries[i] & {ENTRY_W{sel[i]}});
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_insert && !full) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_issue && any_go) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_table_reg  <= '0;
            store_code_reg <= '0;
            float_code_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LAT_TABLE:  lat_table_reg  <= cfg_wdata;
                CFG_STORE_CODE: store_code_reg <= cfg_wdata[OP_W-1:0];
                CFG_FLOAT_CODE: float_code_reg <= cfg_wdata[OP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_valid_reg <= do_issue && any_go;
            res_entry_reg <= (do_issue && any_go) ? picked : '0;
            res_occ_reg   <= OCC_W'(count_next);
            res_space_reg <= (count_next < CNT_W'(WINDOW_DEPTH));
            res_ovf_reg   <= do_insert && full;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_issued_valid    = res_valid_reg;
    assign m_issued_op       = res_entry_reg.op;
    assign m_issued_src1     = res_entry_reg.src1;
    assign m_issued_src2     = res_entry_reg.src2;
    assign m_issued_dest     = res_entry_reg.dest;
    assign m_occupancy       = res_occ_reg;
    assign m_has_space       = res_space_reg;
    assign m_insert_overflow = res_ovf_reg;

endmodule
